/* hw/rtl/csvt_pkg.sv */
package csvt_pkg;

   localparam int FIFO_DEPTH_DEF = 4;

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_NORMAL = 1'b1;

   localparam logic [2:0] REG_CAM_X     = 3'd0;
   localparam logic [2:0] REG_CAM_Y     = 3'd1;
   localparam logic [2:0] REG_CAM_Z     = 3'd2;
   localparam logic [2:0] REG_COS_PITCH = 3'd3;
   localparam logic [2:0] REG_SIN_PITCH = 3'd4;
   localparam logic [2:0] REG_COS_YAW   = 3'd5;
   localparam logic [2:0] REG_SIN_YAW   = 3'd6;

   localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [15:0] cos_pitch;
      logic signed [15:0] sin_pitch;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
   } csr_type;

   // rotated item handed from the front to the back
   typedef struct packed {
      logic               op;
      logic signed [38:0] w0;
      logic signed [38:0] w1;
      logic signed [38:0] w2;
   } rot_item_type;

   typedef struct packed {
      logic        op;
      logic        sat;
      logic        deg;
      logic [2:0]  neg;
      logic [29:0] u0;
      logic [29:0] u1;
      logic [29:0] u2;
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] v2;
   } norm_side_type;

   typedef struct packed {
      logic        op;
      logic        sat;
      logic        deg;
      logic [2:0]  neg;
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] v2;
   } div_side_type;

   // Q2.28 product to Q.14, round half up
   function automatic logic signed [17:0] round_mat(input logic signed [31:0] p);
      logic signed [31:0] t;
      t = p + 32'sd8192;
      return t[31:14];
   endfunction

   // Q16.30 dot product to Q16.16, round half up
   function automatic logic signed [38:0] round_dot(input logic signed [52:0] s);
      logic signed [52:0] t;
      t = s + 53'sd8192;
      return t[52:14];
   endfunction

endpackage

/* hw/rtl/csvt_front.sv */
module csvt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  csvt_pkg::csr_type       csr,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_op,
   input  logic signed [31:0]      in_x,
   input  logic signed [31:0]      in_y,
   input  logic signed [31:0]      in_z,
   output logic                    out_valid,
   input  logic                    out_ready,
   output csvt_pkg::rot_item_type  out_item
);
   import csvt_pkg::*;

   logic signed [17:0] m_ff [0:8];
   logic signed [17:0] m_in [0:8];
   logic signed [32:0] v_ff [0:2];
   logic signed [32:0] v_in [0:2];
   logic signed [50:0] p_ff [0:8];
   logic               op1_ff, op2_ff;
   logic               vld1_ff, vld2_ff, vld3_ff;
   logic               en;
   rot_item_type       item_ff, item_in;

   // matrix follows the registers; the user must change them only while idle, the block does not enforce it
   always_comb begin
      m_in[0] = 18'(csr.cos_yaw);
      m_in[1] = round_mat(csr.sin_yaw * csr.sin_pitch);
      m_in[2] = round_mat(csr.sin_yaw * csr.cos_pitch);
      m_in[3] = '0;
      m_in[4] = 18'(csr.cos_pitch);
      m_in[5] = -18'(csr.sin_pitch);
      m_in[6] = -18'(csr.sin_yaw);
      m_in[7] = round_mat(csr.cos_yaw * csr.sin_pitch);
      m_in[8] = round_mat(csr.cos_yaw * csr.cos_pitch);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) m_ff[i] <= m_in[i];
   end

   assign en       = !vld3_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      v_in[0] = 33'(in_x);
      v_in[1] = 33'(in_y);
      v_in[2] = 33'(in_z);
      if (in_op == OP_VERTEX) begin
         v_in[0] = 33'(in_x) - 33'(csr.cam_x);
         v_in[1] = 33'(in_y) - 33'(csr.cam_y);
         v_in[2] = 33'(in_z) - 33'(csr.cam_z);
      end
   end

   always_comb begin
      item_in.op = op2_ff;
      item_in.w0 = round_dot(53'(p_ff[0]) + 53'(p_ff[1]) + 53'(p_ff[2]));
      item_in.w1 = round_dot(53'(p_ff[3]) + 53'(p_ff[4]) + 53'(p_ff[5]));
      item_in.w2 = round_dot(53'(p_ff[6]) + 53'(p_ff[7]) + 53'(p_ff[8]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) v_ff[j] <= v_in[j];
         op1_ff <= in_op;
         for (int k = 0; k < 9; k++) p_ff[k] <= m_ff[k] * v_ff[k % 3];
         op2_ff  <= op1_ff;
         item_ff <= item_in;
      end
   end

   assign out_valid = vld3_ff;
   assign out_item  = item_ff;

endmodule

/* hw/rtl/csvt_fifo.sv */
module csvt_fifo #(
   parameter int DEPTH = csvt_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  csvt_pkg::rot_item_type  din,
   input  logic                    pop,
   output csvt_pkg::rot_item_type  dout,
   output logic                    empty,
   output logic                    full
);
   import csvt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rot_item_type     mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      rd_in    = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= din;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("transfer into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a transfer");
`endif

endmodule

/* hw/rtl/csvt_isqrt.sv */
module csvt_isqrt #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [61:0]   in_n,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [30:0]   out_root,
   output logic [SW-1:0] out_side
);
   localparam int STAGES = 31;

   logic [61:0]   rem_w  [0:STAGES];
   logic [30:0]   root_w [0:STAGES];
   logic          vld_w  [0:STAGES];
   logic [SW-1:0] side_w [0:STAGES];

   assign rem_w[0]  = in_n;
   assign root_w[0] = '0;
   assign vld_w[0]  = in_valid;
   assign side_w[0] = in_side;

   // one root bit per stage, most significant first
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int BIT = STAGES - 1 - s;
      logic [62:0]   trial;
      logic          take;
      logic [61:0]   rem_ff;
      logic [30:0]   root_ff;
      logic          vld_ff;
      logic [SW-1:0] side_ff;

      assign trial = ({32'd0, root_w[s]} << (BIT + 1)) + (63'd1 << (2 * BIT));
      assign take  = {1'b0, rem_w[s]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) vld_ff <= 1'b0;
         else if (en) vld_ff <= vld_w[s];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= take ? rem_w[s] - trial[61:0] : rem_w[s];
            root_ff <= root_w[s] | (take ? (31'd1 << BIT) : 31'd0);
            side_ff <= side_w[s];
         end
      end

      assign rem_w[s+1]  = rem_ff;
      assign root_w[s+1] = root_ff;
      assign vld_w[s+1]  = vld_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = vld_w[STAGES];
   assign out_root  = root_w[STAGES];
   assign out_side  = side_w[STAGES];

endmodule

/* hw/rtl/csvt_div.sv */
module csvt_div #(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [47:0]   in_num0,
   input  logic [47:0]   in_num1,
   input  logic [47:0]   in_num2,
   input  logic [31:0]   in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [16:0]   out_q0,
   output logic [16:0]   out_q1,
   output logic [16:0]   out_q2,
   output logic [SW-1:0] out_side
);
   localparam int STAGES = 17;

   logic [47:0]   rem_w  [0:STAGES][0:2];
   logic [16:0]   q_w    [0:STAGES][0:2];
   logic [31:0]   den_w  [0:STAGES];
   logic          vld_w  [0:STAGES];
   logic [SW-1:0] side_w [0:STAGES];

   assign rem_w[0][0] = in_num0;
   assign rem_w[0][1] = in_num1;
   assign rem_w[0][2] = in_num2;
   assign q_w[0][0]   = '0;
   assign q_w[0][1]   = '0;
   assign q_w[0][2]   = '0;
   assign den_w[0]    = in_den;
   assign vld_w[0]    = in_valid;
   assign side_w[0]   = in_side;

   // restoring division, one quotient bit per stage, three lanes share the divisor
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int BIT = STAGES - 1 - s;
      logic [48:0]   dsh;
      logic [31:0]   den_ff;
      logic          vld_ff;
      logic [SW-1:0] side_ff;

      assign dsh = {17'd0, den_w[s]} << BIT;

      always_ff @(posedge clock) begin
         if (reset) vld_ff <= 1'b0;
         else if (en) vld_ff <= vld_w[s];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff  <= den_w[s];
            side_ff <= side_w[s];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic        take;
         logic [47:0] rem_ff;
         logic [16:0] q_ff;

         assign take = {1'b0, rem_w[s][l]} >= dsh;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= take ? rem_w[s][l] - dsh[47:0] : rem_w[s][l];
               q_ff   <= q_w[s][l] | (take ? (17'd1 << BIT) : 17'd0);
            end
         end

         assign rem_w[s+1][l] = rem_ff;
         assign q_w[s+1][l]   = q_ff;
      end

      assign den_w[s+1]  = den_ff;
      assign vld_w[s+1]  = vld_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = vld_w[STAGES];
   assign out_q0    = q_w[STAGES][0];
   assign out_q1    = q_w[STAGES][1];
   assign out_q2    = q_w[STAGES][2];
   assign out_side  = side_w[STAGES];

endmodule

/* hw/rtl/csvt_back.sv */
module csvt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  csvt_pkg::rot_item_type  in_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_degenerate,
   output logic                    rsp_saturated
);
   import csvt_pkg::*;

   logic               en;
   logic signed [38:0] w_a   [0:2];
   logic [38:0]        mag_a [0:2];
   logic [29:0]        u_a   [0:2];
   logic [31:0]        v_a   [0:2];
   logic [38:0]        mx;
   logic [3:0]         shk;
   logic               sat_any;
   norm_side_type      side1_in, side1_ff, side2_ff, side3_in, side3_ff;
   logic               k0_1_ff, k0_2_ff;
   logic               vld1_ff, vld2_ff, vld3_ff, vld4_ff, out_vld_ff;
   logic [59:0]        sq_ff [0:2];
   logic [61:0]        sum_in, sum_ff;
   logic               sq_vld;
   logic [30:0]        sq_root;
   norm_side_type      sq_side;
   logic [47:0]        num_ff [0:2];
   logic [31:0]        den_ff;
   div_side_type       dside_in, dside_ff;
   logic               dv_vld;
   logic [16:0]        q0, q1, q2;
   div_side_type       dv_side;
   logic [31:0]        res_in [0:2];
   logic [31:0]        res_ff [0:2];
   logic               deg_ff, sat_ff;

   assign en       = !out_vld_ff || rsp_ready;
   assign in_ready = en;

   // magnitudes, common scale-down, vertex clamp
   always_comb begin
      w_a[0]  = in_item.w0;
      w_a[1]  = in_item.w1;
      w_a[2]  = in_item.w2;
      mx      = '0;
      sat_any = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag_a[i] = w_a[i][38] ? 39'(-w_a[i]) : 39'(w_a[i]);
         if (mag_a[i] > mx) mx = mag_a[i];
         v_a[i] = w_a[i][31:0];
         if (!((&w_a[i][38:31]) || !(|w_a[i][38:31]))) begin
            v_a[i]  = w_a[i][38] ? 32'h8000_0000 : 32'h7fff_ffff;
            sat_any = 1'b1;
         end
      end
      shk = '0;
      for (int b = 30; b <= 38; b++) begin
         if (mx[b]) shk = 4'(b - 29);
      end
      for (int i = 0; i < 3; i++) u_a[i] = 30'(mag_a[i] >> shk);
      side1_in.op  = in_item.op;
      side1_in.sat = (in_item.op == OP_VERTEX) && sat_any;
      side1_in.deg = 1'b0;
      side1_in.neg = {w_a[2][38], w_a[1][38], w_a[0][38]};
      side1_in.u0  = u_a[0];
      side1_in.u1  = u_a[1];
      side1_in.u2  = u_a[2];
      side1_in.v0  = v_a[0];
      side1_in.v1  = v_a[1];
      side1_in.v2  = v_a[2];
   end

   always_comb begin
      sum_in       = 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
      side3_in     = side2_ff;
      side3_in.deg = (side2_ff.op == OP_NORMAL) && k0_2_ff && (sum_in <= 62'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vld4_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff    <= in_valid;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         vld4_ff    <= sq_vld;
         out_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         k0_1_ff  <= (shk == '0);
         sq_ff[0] <= side1_ff.u0 * side1_ff.u0;
         sq_ff[1] <= side1_ff.u1 * side1_ff.u1;
         sq_ff[2] <= side1_ff.u2 * side1_ff.u2;
         side2_ff <= side1_ff;
         k0_2_ff  <= k0_1_ff;
         sum_ff   <= sum_in;
         side3_ff <= side3_in;
      end
   end

   csvt_isqrt #(.SW($bits(norm_side_type))) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld3_ff),
      .in_n      (sum_ff),
      .in_side   (side3_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // numerator 2*u*65536 + L, divisor 2*L
   always_comb begin
      dside_in.op  = sq_side.op;
      dside_in.sat = sq_side.sat;
      dside_in.deg = sq_side.deg;
      dside_in.neg = sq_side.neg;
      dside_in.v0  = sq_side.v0;
      dside_in.v1  = sq_side.v1;
      dside_in.v2  = sq_side.v2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= {1'b0, sq_side.u0, 17'd0} + 48'(sq_root);
         num_ff[1] <= {1'b0, sq_side.u1, 17'd0} + 48'(sq_root);
         num_ff[2] <= {1'b0, sq_side.u2, 17'd0} + 48'(sq_root);
         den_ff    <= {sq_root, 1'b0};
         dside_ff  <= dside_in;
      end
   end

   csvt_div #(.SW($bits(div_side_type))) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld4_ff),
      .in_num0   (num_ff[0]),
      .in_num1   (num_ff[1]),
      .in_num2   (num_ff[2]),
      .in_den    (den_ff),
      .in_side   (dside_ff),
      .out_valid (dv_vld),
      .out_q0    (q0),
      .out_q1    (q1),
      .out_q2    (q2),
      .out_side  (dv_side)
   );

   always_comb begin
      res_in[0] = dv_side.neg[0] ? -{15'd0, q0} : {15'd0, q0};
      res_in[1] = dv_side.neg[1] ? -{15'd0, q1} : {15'd0, q1};
      res_in[2] = dv_side.neg[2] ? -{15'd0, q2} : {15'd0, q2};
      if (dv_side.op == OP_VERTEX) begin
         res_in[0] = dv_side.v0;
         res_in[1] = dv_side.v1;
         res_in[2] = dv_side.v2;
      end else if (dv_side.deg) begin
         res_in[0] = '0;
         res_in[1] = '0;
         res_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) res_ff[i] <= res_in[i];
         deg_ff <= dv_side.deg;
         sat_ff <= dv_side.sat;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_x      = res_ff[0];
   assign rsp_out_y      = res_ff[1];
   assign rsp_out_z      = res_ff[2];
   assign rsp_degenerate = deg_ff;
   assign rsp_saturated  = sat_ff;

endmodule

/* hw/rtl/camera_space_vertex_transform_unit.sv */
// Camera-space transform: each request is a vertex (operation 0), which has the
// camera position subtracted and is rotated by the pitch/yaw view matrix, or a
// normal (operation 1), which is rotated and scaled to unit length in Q16.16.
// One item is taken per cycle while the response side does not stall; a request
// passes through the three-stage front (matrix multiply and rounding), the queue,
// and the back end's 31-stage square root and 17-stage dividers, one root or
// quotient bit per stage.
// Write the camera and trig registers through the csr port only while idle.
module camera_space_vertex_transform_unit #(
   parameter int FIFO_DEPTH = csvt_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_degenerate,
   output logic               rsp_saturated
);
   import csvt_pkg::*;

   csr_type      csr_ff;
   logic         fe_valid, fe_ready;
   rot_item_type fe_item, q_item;
   logic         q_empty, q_full, q_pop, be_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.cam_x     <= '0;
         csr_ff.cam_y     <= '0;
         csr_ff.cam_z     <= '0;
         csr_ff.cos_pitch <= TRIG_ONE;
         csr_ff.sin_pitch <= '0;
         csr_ff.cos_yaw   <= TRIG_ONE;
         csr_ff.sin_yaw   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CAM_X:     csr_ff.cam_x     <= csr_data;
            REG_CAM_Y:     csr_ff.cam_y     <= csr_data;
            REG_CAM_Z:     csr_ff.cam_z     <= csr_data;
            REG_COS_PITCH: csr_ff.cos_pitch <= csr_data[15:0];
            REG_SIN_PITCH: csr_ff.sin_pitch <= csr_data[15:0];
            REG_COS_YAW:   csr_ff.cos_yaw   <= csr_data[15:0];
            REG_SIN_YAW:   csr_ff.sin_yaw   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   csvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_operation),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_z      (req_in_z),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_item  (fe_item)
   );

   // take a transfer into a full queue only while the head leaves
   assign q_pop    = !q_empty && be_ready;
   assign fe_ready = !q_full || q_pop;

   csvt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fe_valid && fe_ready),
      .din   (fe_item),
      .pop   (q_pop),
      .dout  (q_item),
      .empty (q_empty),
      .full  (q_full)
   );

   csvt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (!q_empty),
      .in_ready       (be_ready),
      .in_item        (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

/* verif/tb_camera_space_vertex_transform_unit.sv */
`timescale 1ns / 100ps

module tb_camera_space_vertex_transform_unit;
   import csvt_pkg::*;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        deg;
      logic        sat;
   } view_vec_type;

   class view_scoreboard;
      logic signed [31:0] cam_x = 0, cam_y = 0, cam_z = 0;
      logic signed [15:0] cos_pitch = TRIG_ONE, sin_pitch = 0;
      logic signed [15:0] cos_yaw = TRIG_ONE, sin_yaw = 0;
      view_vec_type pending[$];
      int errors = 0;

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            REG_CAM_X: cam_x = data;
            REG_CAM_Y: cam_y = data;
            REG_CAM_Z: cam_z = data;
            REG_COS_PITCH: cos_pitch = data[15:0];
            REG_SIN_PITCH: sin_pitch = data[15:0];
            REG_COS_YAW: cos_yaw = data[15:0];
            REG_SIN_YAW: sin_yaw = data[15:0];
            default: ;
         endcase
      endfunction

      function longint half_up14(longint p);
         return (p + 64'sd8192) >>> 14;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // work out the view-space result of one accepted request
      function void note_request(logic op, logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
         longint m[3][3];
         longint v[3], w[3];
         longint unsigned a[3], mx, sum, len, q;
         int k;
         view_vec_type e;
         m[0][0] = cos_yaw;
         m[0][1] = half_up14(longint'(sin_yaw) * sin_pitch);
         m[0][2] = half_up14(longint'(sin_yaw) * cos_pitch);
         m[1][0] = 0;
         m[1][1] = cos_pitch;
         m[1][2] = -longint'(sin_pitch);
         m[2][0] = -longint'(sin_yaw);
         m[2][1] = half_up14(longint'(cos_yaw) * sin_pitch);
         m[2][2] = half_up14(longint'(cos_yaw) * cos_pitch);
         v[0] = x;
         v[1] = y;
         v[2] = z;
         if (op == OP_VERTEX) begin
            v[0] -= cam_x;
            v[1] -= cam_y;
            v[2] -= cam_z;
         end
         for (int i = 0; i < 3; i++)
            w[i] = half_up14(m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2]);
         e = '{x: 0, y: 0, z: 0, deg: 0, sat: 0};
         if (op == OP_VERTEX) begin
            for (int i = 0; i < 3; i++) begin
               if (w[i] > 64'sd2147483647) begin
                  w[i] = 64'sd2147483647;
                  e.sat = 1;
               end
               if (w[i] < -64'sd2147483648) begin
                  w[i] = -64'sd2147483648;
                  e.sat = 1;
               end
            end
         end else begin
            mx = 0;
            for (int i = 0; i < 3; i++) begin
               a[i] = (w[i] < 0) ? -w[i] : w[i];
               if (a[i] > mx) mx = a[i];
            end
            k = 0;
            while ((mx >> k) >= (64'd1 << 30)) k++;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               a[i] = a[i] >> k;
               sum += a[i] * a[i];
            end
            if (k == 0 && sum <= 1) begin
               e.deg = 1;
               w = '{0, 0, 0};
            end else begin
               len = int_sqrt(sum);
               for (int i = 0; i < 3; i++) begin
                  q = (2 * (a[i] << 16) + len) / (2 * len);
                  w[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
               end
            end
         end
         e.x = w[0][31:0];
         e.y = w[1][31:0];
         e.z = w[2][31:0];
         pending.push_back(e);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
         errors++;
      endfunction

      function void check_result(view_vec_type r);
         view_vec_type e;
         if (pending.size() == 0) begin
            report("unexpected result", r.x, 0);
            return;
         end
         e = pending.pop_front();
         if (r.x !== e.x) report("out_x", r.x, e.x);
         if (r.y !== e.y) report("out_y", r.y, e.y);
         if (r.z !== e.z) report("out_z", r.z, e.z);
         if (r.deg !== e.deg) report("degenerate", r.deg, e.deg);
         if (r.sat !== e.sat) report("saturated", r.sat, e.sat);
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = REG_CAM_X;
   logic [31:0] csr_data = 0;
   logic req_valid = 0, req_ready, req_operation = OP_VERTEX;
   logic signed [31:0] req_in_x = 0, req_in_y = 0, req_in_z = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_degenerate, rsp_saturated;

   view_scoreboard sb = new();
   int unsigned ready_cycle = 0;
   bit paused_once = 0;

   camera_space_vertex_transform_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_in_x, req_in_y, req_in_z);
         if (rsp_valid && rsp_ready)
            sb.check_result('{x: rsp_out_x, y: rsp_out_y, z: rsp_out_z,
                              deg: rsp_degenerate, sat: rsp_saturated});
      end
   end

   // receiver stalls: always ready, random, and periodic stretches
   always @(negedge clock) begin
      ready_cycle <= ready_cycle + 1;
      case ((ready_cycle / 300) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ((ready_cycle % 7) < 3);
      endcase
   end

   initial begin
      #20_000_000;
      $display("[camera_space_vertex_transform_unit] ERROR");
      $finish;
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 262144) - 131072;
         2: return $signed($urandom) >>> $urandom_range(0, 31);
         3: case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 0;
               3: return 32'hffff_ffff;
               default: return 1;
            endcase
         default: return $urandom_range(0, 16) - 8;
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic send_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_valid <= 1;
      req_operation <= op;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   task automatic load_view(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [15:0] cp, logic [15:0] sp, logic [15:0] cw,
                            logic [15:0] sw);
      csr_write(REG_CAM_X, cx);
      csr_write(REG_CAM_Y, cy);
      csr_write(REG_CAM_Z, cz);
      csr_write(REG_COS_PITCH, {16'($urandom), cp});
      csr_write(REG_SIN_PITCH, {16'($urandom), sp});
      csr_write(REG_COS_YAW, {16'($urandom), cw});
      csr_write(REG_SIN_YAW, {16'($urandom), sw});
      csr_valid <= 0;
   endtask

   // a unit-length pair in Q1.14 with random signs
   task automatic pick_angle(output logic [15:0] c, output logic [15:0] s);
      int ci;
      ci = $urandom_range(0, 32768) - 16384;
      c = 16'(ci);
      s = 16'($rtoi($sqrt(268435456.0 - real'(ci) * ci) + 0.5));
      if ($urandom_range(0, 1)) s = -s;
   endtask

   task automatic run_random(int n, bit pause);
      int sent, len, gap;
      logic op;
      sent = 0;
      while (sent < n) begin
         len = $urandom_range(1, 40);
         for (int i = 0; i < len && sent < n; i++) begin
            op = ($urandom_range(0, 1) == 1) ? OP_NORMAL : OP_VERTEX;
            send_item(op, pick_word(), pick_word(), pick_word());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (pause && !paused_once && sent >= n / 2) begin
            if (gap == 0) gap = 1;
         end
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         // hold off until the pipeline is empty
         if (pause && !paused_once && sent >= n / 2) begin
            paused_once = 1;
            wait_drain();
         end
      end
      if (gap == 0) req_valid <= 0;
   endtask

   initial begin
      logic [15:0] c1, s1, c2, s2;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // identity view: extremes, zero and tiny normals, both operations
      send_item(OP_VERTEX, 0, 0, 0);
      send_item(OP_NORMAL, 0, 0, 0);
      send_item(OP_NORMAL, 1, 0, 0);
      send_item(OP_NORMAL, 0, 32'hffff_ffff, 0);
      send_item(OP_NORMAL, 1, 1, 0);
      send_item(OP_NORMAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(OP_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 5);
      send_item(OP_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_VERTEX, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
      req_valid <= 0;
      wait_drain();

      // camera at one corner, out-of-range trig: clamps both ways
      load_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                16'h8000, 16'h7fff, 16'h8000, 16'h8000);
      send_item(OP_VERTEX, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_item(OP_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_NORMAL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_item(OP_NORMAL, 1, 1, 1);
      run_random(150, 0);
      wait_drain();

      load_view(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                16'hc000, 16'hc000, 16'hc000, 16'hc000);
      run_random(150, 1);
      wait_drain();

      load_view(0, 0, 0, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
      run_random(150, 0);
      wait_drain();

      for (int p = 0; p < 8; p++) begin
         pick_angle(c1, s1);
         pick_angle(c2, s2);
         if (p % 4 == 3) begin
            c1 = 16'($urandom);
            s1 = 16'($urandom);
            c2 = 16'($urandom);
            s2 = 16'($urandom);
         end
         load_view(pick_word(), pick_word(), pick_word(), c1, s1, c2, s2);
         run_random(165, 0);
         wait_drain();
      end

      if (sb.pending.size() != 0) sb.report("left over", sb.pending.size(), 0);
      if (sb.errors == 0) begin
         $display("[camera_space_vertex_transform_unit] OK");
      end else begin
         $display("[camera_space_vertex_transform_unit] ERROR");
      end
      $finish;
   end
endmodule
